>>> rtl/core/hough_line_vote_accumulator_unit_assert.svh
// ----------------------------------------------------------------------------
// hough line vote accumulator assertion macros
// concurrent checks sampled on clk, switched off while rst is high
// ----------------------------------------------------------------------------
`ifndef HOUGH_LINE_VOTE_ACCUMULATOR_UNIT_ASSERT_SVH
`define HOUGH_LINE_VOTE_ACCUMULATOR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define HLVA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define HLVA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/hlva_pkg.sv
// ----------------------------------------------------------------------------
// hlva_pkg
// types, codes, widths and the trig table builder of the line vote accumulator
// ----------------------------------------------------------------------------
package hlva_pkg;

  // item function codes
  typedef enum logic [1:0] {
    FUNC_VOTE  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // sequencer states
  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_VOTE  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_READ  = 5'b10000
  } state_t;

  // register indexes and apb port widths
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS     = 2'd2;

  // field widths
  localparam int THR_W      = 8;
  localparam int DIM_W      = 10;
  localparam int PIX_W      = 9;
  localparam int MAG_W      = 8;
  localparam int RHO_IN_W   = 11;
  localparam int THETA_IN_W = 8;
  localparam int OUT_W      = 16;
  localparam int FUNC_W     = 2;

  localparam logic [THR_W-1:0] THR_RESET  = 8'd200;
  localparam logic [DIM_W-1:0] DIM_RESET  = 10'd512;

  // datapath widths
  localparam int TRIG_W     = 16;
  localparam int FRAC_BITS  = 14;
  localparam int PROD_W     = PIX_W + 1 + TRIG_W;
  localparam int PROJ_W     = PROD_W + 1;
  localparam int FLOOR_W    = PROJ_W - FRAC_BITS;
  localparam int OFS_W      = DIM_W + 1;
  localparam int RHO_WIDE_W   = 16;
  localparam int THETA_WIDE_W = 10;
  localparam int CNT_WIDE_W   = 32;

  // q30 constants for the table build
  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
  localparam logic [63:0] PI_Q30  = (64'd314159265 << 30) / 64'd100000000;

  // q1.14 cosine or sine of an integer degree, evaluated at elaboration only
  function automatic logic signed [TRIG_W-1:0] trig_q14(input int unsigned t,
                                                       input logic want_cos);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint ss;
    longint cc;
    longint s;
    longint c;
    longint so;
    longint co;
    longint v;
    longint m;
    int unsigned quad;
    int unsigned r;
    int unsigned d;
    quad = (t / 90) % 4;
    r    = t % 90;
    d    = (r <= 45) ? r : 90 - r;
    x    = (PI_Q30 * 64'(d)) / 64'd180;
    x2   = (x * x) >> 30;
    ss   = longint'(x);
    cc   = longint'(ONE_Q30);
    ts   = x;
    tc   = ONE_Q30;
    // taylor terms through x^15 and x^14, each truncated
    ts = ((ts * x2) >> 30) / 64'd6;    tc = ((tc * x2) >> 30) / 64'd2;
    ss = ss - longint'(ts);            cc = cc - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd20;   tc = ((tc * x2) >> 30) / 64'd12;
    ss = ss + longint'(ts);            cc = cc + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd42;   tc = ((tc * x2) >> 30) / 64'd30;
    ss = ss - longint'(ts);            cc = cc - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd72;   tc = ((tc * x2) >> 30) / 64'd56;
    ss = ss + longint'(ts);            cc = cc + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd110;  tc = ((tc * x2) >> 30) / 64'd90;
    ss = ss - longint'(ts);            cc = cc - longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd156;  tc = ((tc * x2) >> 30) / 64'd132;
    ss = ss + longint'(ts);            cc = cc + longint'(tc);
    ts = ((ts * x2) >> 30) / 64'd210;  tc = ((tc * x2) >> 30) / 64'd182;
    ss = ss - longint'(ts);            cc = cc - longint'(tc);
    if (r <= 45) begin
      s = ss;
      c = cc;
    end else begin
      s = cc;
      c = ss;
    end
    case (quad)
      0: begin
        so = s;
        co = c;
      end
      1: begin
        so = c;
        co = -s;
      end
      2: begin
        so = -s;
        co = -c;
      end
      default: begin
        so = -c;
        co = s;
      end
    endcase
    v = want_cos ? co : so;
    m = (v < 0) ? -v : v;
    m = (m + 64'sd32768) >>> 16;
    trig_q14 = TRIG_W'((v < 0) ? -m : m);
  endfunction

endpackage

>>> rtl/core/hlva_ram.sv
// ----------------------------------------------------------------------------
// hlva_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module hlva_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while rd_en is low
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/hough_line_vote_accumulator_unit.sv
// vote item: one bin read-modify-write per angle through the single bin ram, behind a
//   4-stage angle pipeline; items stall until the pipeline has drained
// read item: bin read from the ram, count registered once the result register is free
// clear item, or vote at or below threshold: the unit stays idle, with no stall
// rst (synchronous) restores registers, then sweeps all 4*MAX_DIM * 2**clog2(ANGLE_STEPS)
//   ram words (524288 by default) to zero with item_stall high
// ----------------------------------------------------------------------------
// hough_line_vote_accumulator_unit
// hough line voting engine: per-angle rho bins with saturating counts
// ----------------------------------------------------------------------------
`include "hough_line_vote_accumulator_unit_assert.svh"

module hough_line_vote_accumulator_unit #(
  parameter int MAX_DIM     = 512,
  parameter int ANGLE_STEPS = 180,
  parameter int COUNT_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  func,
  input  logic [8:0]  pixel_row,
  input  logic [8:0]  pixel_col,
  input  logic [7:0]  magnitude,
  input  logic [10:0] rho_index,
  input  logic [7:0]  theta_index,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] bin_count,
  // apb config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import hlva_pkg::*;

  localparam int RHO_BINS   = 4 * MAX_DIM;
  localparam int RHO_BITS   = $clog2(RHO_BINS);
  localparam int THETA_BITS = (ANGLE_STEPS > 1) ? $clog2(ANGLE_STEPS) : 1;
  localparam int ADDR_W     = RHO_BITS + THETA_BITS;
  localparam int DEPTH      = RHO_BINS * (2 ** THETA_BITS);
  localparam int SUM_W      = (RHO_BITS + 2 > FLOOR_W + 1) ? RHO_BITS + 2 : FLOOR_W + 1;

  // config registers
  logic [THR_W-1:0] edge_threshold;
  logic [DIM_W-1:0] image_rows;
  logic [DIM_W-1:0] image_cols;
  logic             cfg_write;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_idx   = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THR_RESET;
      image_rows     <= DIM_RESET;
      image_cols     <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_EDGE_THRESHOLD: edge_threshold <= pwdata[THR_W-1:0];
        REG_IMAGE_ROWS:     image_rows     <= pwdata[DIM_W-1:0];
        REG_IMAGE_COLS:     image_cols     <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_EDGE_THRESHOLD: prdata = PDATA_W'(edge_threshold);
      REG_IMAGE_ROWS:     prdata = PDATA_W'(image_rows);
      REG_IMAGE_COLS:     prdata = PDATA_W'(image_cols);
      default:            prdata = '0;
    endcase
  end

  // q1.14 trig tables, built at elaboration
  logic signed [TRIG_W-1:0] cos_tab [ANGLE_STEPS];
  logic signed [TRIG_W-1:0] sin_tab [ANGLE_STEPS];

  for (genvar g = 0; g < ANGLE_STEPS; g++) begin : g_trig
    localparam logic signed [TRIG_W-1:0] COS_V = trig_q14(g, 1'b1);
    localparam logic signed [TRIG_W-1:0] SIN_V = trig_q14(g, 1'b0);
    assign cos_tab[g] = COS_V;
    assign sin_tab[g] = SIN_V;
  end

  // sequencer
  state_t state;
  state_t state_next;

  logic                  item_accept;
  logic                  vote_go;
  logic                  out_free;
  logic                  pipe_busy;
  logic [ADDR_W-1:0]     clr_addr;
  logic                  clr_last;
  logic [THETA_BITS-1:0] t_cnt;
  logic                  t_last;

  // addressed bin of read and clear beats
  logic [RHO_WIDE_W-1:0]   rho_wide;
  logic [THETA_WIDE_W-1:0] theta_wide;
  logic                    port_inside;
  logic [ADDR_W-1:0]       port_addr;

  assign item_stall  = (state != ST_IDLE);
  assign item_accept = item_valid && !item_stall;
  assign vote_go     = (func == FUNC_VOTE) && (magnitude > edge_threshold);
  assign out_free    = !result_valid || !result_stall;
  assign clr_last    = (clr_addr == ADDR_W'(DEPTH - 1));
  assign t_last      = (t_cnt == THETA_BITS'(ANGLE_STEPS - 1));

  assign rho_wide    = RHO_WIDE_W'(rho_index);
  assign theta_wide  = THETA_WIDE_W'(theta_index);
  assign port_inside = (rho_wide < RHO_WIDE_W'(RHO_BINS)) &&
                       (theta_wide < THETA_WIDE_W'(ANGLE_STEPS));
  assign port_addr   = {rho_wide[RHO_BITS-1:0], theta_wide[THETA_BITS-1:0]};

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_accept) begin
          unique case (func)
            FUNC_VOTE: if (vote_go) state_next = ST_VOTE;
            FUNC_READ: state_next = ST_READ;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_VOTE: begin
        if (t_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) state_next = ST_IDLE;
      end
      ST_READ: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      clr_addr <= '0;
      t_cnt    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_VOTE) begin
        t_cnt <= t_last ? '0 : t_cnt + THETA_BITS'(1);
      end
    end
  end

  // beat capture
  logic [PIX_W-1:0] vote_row;
  logic [PIX_W-1:0] vote_col;
  logic             read_inside;

  always_ff @(posedge clk) begin
    if (item_accept) begin
      vote_row    <= pixel_row;
      vote_col    <= pixel_col;
      read_inside <= port_inside;
    end
  end

  // angle pipeline: table lookup, products, rho and range, bin update
  logic                     s1_v;
  logic [THETA_BITS-1:0]    s1_t;
  logic signed [TRIG_W-1:0] s1_cos;
  logic signed [TRIG_W-1:0] s1_sin;
  logic                     s2_v;
  logic [THETA_BITS-1:0]    s2_t;
  logic signed [PROD_W-1:0] s2_pc;
  logic signed [PROD_W-1:0] s2_ps;
  logic                     s3_ok;
  logic [ADDR_W-1:0]        s3_addr;
  logic                     s4_v;
  logic [ADDR_W-1:0]        s4_addr;

  logic signed [PROJ_W-1:0]  proj;
  logic signed [FLOOR_W-1:0] proj_fl;
  logic        [OFS_W-1:0]   offset;
  logic signed [SUM_W-1:0]   rho_full;
  logic                      rho_ok;

  assign proj    = PROJ_W'(s2_pc) + PROJ_W'(s2_ps);
  // arithmetic shift is floor division for negative projections too
  assign proj_fl = FLOOR_W'(proj >>> FRAC_BITS);
  assign offset  = OFS_W'(image_rows) + OFS_W'(image_cols);
  assign rho_full = SUM_W'(proj_fl) + $signed(SUM_W'(offset));
  assign rho_ok   = (rho_full >= 0) && (rho_full < $signed(SUM_W'(RHO_BINS)));

  assign pipe_busy = s1_v || s2_v || s3_ok || s4_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_ok <= 1'b0;
      s4_v  <= 1'b0;
    end else begin
      s1_v  <= (state == ST_VOTE);
      s2_v  <= s1_v;
      s3_ok <= s2_v && rho_ok;
      s4_v  <= s3_ok;
    end
  end

  always_ff @(posedge clk) begin
    s1_t    <= t_cnt;
    s1_cos  <= cos_tab[t_cnt];
    s1_sin  <= sin_tab[t_cnt];
    s2_t    <= s1_t;
    s2_pc   <= $signed({1'b0, vote_col}) * s1_cos;
    s2_ps   <= $signed({1'b0, vote_row}) * s1_sin;
    s3_addr <= {rho_full[RHO_BITS-1:0], s2_t};
    s4_addr <= s3_addr;
  end

  // bin ram port selection
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;
  logic                  ram_rd_en;
  logic [ADDR_W-1:0]     ram_rd_addr;
  logic [COUNT_BITS-1:0] ram_rd_data;

  always_comb begin
    priority if (state == ST_INIT) begin
      ram_we      = 1'b1;
      ram_wr_addr = clr_addr;
      ram_wr_data = '0;
    end else if (item_accept && (func == FUNC_CLEAR)) begin
      ram_we      = port_inside;
      ram_wr_addr = port_addr;
      ram_wr_data = '0;
    end else begin
      // saturated bins are left as they are
      ram_we      = s4_v && (ram_rd_data != '1);
      ram_wr_addr = s4_addr;
      ram_wr_data = ram_rd_data + COUNT_BITS'(1);
    end
  end

  always_comb begin
    priority if (item_accept && (func == FUNC_READ)) begin
      ram_rd_en   = 1'b1;
      ram_rd_addr = port_addr;
    end else begin
      ram_rd_en   = s3_ok;
      ram_rd_addr = s3_addr;
    end
  end

  hlva_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_bins (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // result register
  logic [CNT_WIDE_W-1:0] cnt_wide;

  assign cnt_wide = CNT_WIDE_W'(ram_rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_READ) && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_READ) && out_free) begin
      bin_count <= read_inside ? cnt_wide[OUT_W-1:0] : '0;
    end
  end

  // checks
  `HLVA_ASSERT_NOW(a_rmw_no_clash, ram_we && ram_rd_en, ram_wr_addr != ram_rd_addr, "bin ram read and write hit the same address")
  `HLVA_ASSERT_NOW(a_idle_pipe_empty, state == ST_IDLE, !pipe_busy, "angle pipeline busy while idle")
  `HLVA_ASSERT_NOW(a_sweep_complete, (state == ST_IDLE) && $past(state == ST_INIT), $past(clr_addr) == ADDR_W'(DEPTH - 1), "clearing sweep ended early")
  `HLVA_ASSERT_NEXT(a_vote_issue, state == ST_VOTE, s1_v, "vote state issued no angle")

endmodule

>>> dv/tb_hough_line_vote_accumulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hough_line_vote_accumulator_unit
// self-checking bench for the hough line vote accumulator: a queue-fed item
// driver, a randomly stalling result sink and an apb writer drive the unit,
// while a per-item bin tally with its own q1.14 trig tables predicts every
// read beat. runs several register settings, extremes included.
// ----------------------------------------------------------------------------
module tb_hough_line_vote_accumulator_unit;
  import hlva_pkg::*;

  localparam int ANGLES      = 180;
  localparam int RHO_SPAN    = 4 * 512;
  localparam int VOTE_DRAIN  = 256;
  localparam int LONG_HOLD   = 1500;
  localparam longint CYCLE_LIMIT = 4_000_000;
  localparam logic [1:0] FUNC_SPARE = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam bit [63:0] UNIT_Q30 = 64'd1 << 30;
  localparam bit [63:0] PI_FIX_Q30 = (64'd314159265 << 30) / 64'd100000000;

  typedef struct {
    logic [1:0]  op;
    logic [8:0]  row;
    logic [8:0]  col;
    logic [7:0]  mag;
    logic [10:0] rho;
    logic [7:0]  theta;
  } hough_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic [1:0]  func = '0;
  logic [8:0]  pixel_row = '0;
  logic [8:0]  pixel_col = '0;
  logic [7:0]  magnitude = '0;
  logic [10:0] rho_index = '0;
  logic [7:0]  theta_index = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [15:0] bin_count;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  hough_line_vote_accumulator_unit i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .func(func), .pixel_row(pixel_row), .pixel_col(pixel_col),
    .magnitude(magnitude), .rho_index(rho_index), .theta_index(theta_index),
    .result_valid(result_valid), .result_stall(result_stall), .bin_count(bin_count),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predicted state
  int          cos_tab [ANGLES];
  int          sin_tab [ANGLES];
  bit [15:0]   vote_tally [RHO_SPAN * ANGLES];
  logic [7:0]  thr_now  = THR_RESET;
  logic [9:0]  rows_now = DIM_RESET;
  logic [9:0]  cols_now = DIM_RESET;
  logic [15:0] bin_count_due [$];

  hough_item_t pending [$];
  logic [17:0] recent_px [$];
  int          mismatches = 0;
  longint      cycle_count = 0;
  bit          item_beat = 1'b0;
  bit          result_beat = 1'b0;
  int          hold_left = 0;

  // append one item to the driver queue
  function automatic void enqueue_item(input hough_item_t it);
    pending.insert(pending.size(), it);
  endfunction

  // sine and cosine of d degrees (0..45) in q30, truncated taylor terms
  function automatic void taylor_q30(input int unsigned d, output longint s,
                                     output longint c);
    bit [63:0]   x;
    bit [63:0]   x2;
    bit [63:0]   ts;
    bit [63:0]   tc;
    int unsigned k;
    x  = (PI_FIX_Q30 * 64'(d)) / 64'd180;
    x2 = (x * x) >> 30;
    ts = x;
    tc = UNIT_Q30;
    s  = longint'(x);
    c  = longint'(UNIT_Q30);
    for (k = 1; k <= 7; k++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        s = s - longint'(ts);
        c = c - longint'(tc);
      end else begin
        s = s + longint'(ts);
        c = c + longint'(tc);
      end
    end
  endfunction

  // q30 to q1.14, half away from zero
  function automatic int q30_to_q14(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + 64'sd32768) >>> 16;
    return int'((v < 0) ? -m : m);
  endfunction

  function automatic void build_trig_tables();
    int unsigned quad;
    int unsigned r;
    longint s;
    longint c;
    longint so;
    longint co;
    for (int t = 0; t < ANGLES; t++) begin
      quad = (t / 90) % 4;
      r    = t % 90;
      if (r <= 45) taylor_q30(r, s, c);
      else taylor_q30(90 - r, c, s);
      case (quad)
        0: begin
          so = s;
          co = c;
        end
        1: begin
          so = c;
          co = -s;
        end
        2: begin
          so = -s;
          co = -c;
        end
        default: begin
          so = -c;
          co = s;
        end
      endcase
      sin_tab[t] = q30_to_q14(so);
      cos_tab[t] = q30_to_q14(co);
    end
  endfunction

  // offset rho of a pixel at angle t under the current register values
  function automatic int project_rho(input logic [8:0] row, input logic [8:0] col,
                                     input int t);
    int p;
    p = int'(col) * cos_tab[t] + int'(row) * sin_tab[t];
    return (p >>> 14) + int'(rows_now) + int'(cols_now);
  endfunction

  function automatic void cast_pixel_votes(input logic [8:0] row, input logic [8:0] col);
    int r;
    int at;
    for (int t = 0; t < ANGLES; t++) begin
      r = project_rho(row, col, t);
      if (r >= 0 && r < RHO_SPAN) begin
        at = r * ANGLES + t;
        if (vote_tally[at] != 16'hFFFF) vote_tally[at] = vote_tally[at] + 16'd1;
      end
    end
  endfunction

  function automatic void apply_item(input hough_item_t it);
    bit in_range;
    int at;
    in_range = (it.rho < RHO_SPAN) && (it.theta < ANGLES);
    at = in_range ? int'(it.rho) * ANGLES + int'(it.theta) : 0;
    case (it.op)
      FUNC_VOTE: begin
        if (it.mag > thr_now) cast_pixel_votes(it.row, it.col);
      end
      FUNC_READ: begin
        bin_count_due.insert(bin_count_due.size(), in_range ? vote_tally[at] : 16'd0);
      end
      FUNC_CLEAR: begin
        if (in_range) vote_tally[at] = 16'd0;
      end
      default: ;
    endcase
  endfunction

  function automatic void report_miss(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s: expected bin_count %0d, got %0d", $realtime, what, want, got);
  endfunction

  // sample both channels and the config port at the rising edge
  always @(posedge clk) begin
    hough_item_t it;
    item_beat   = item_valid && !item_stall;
    result_beat = result_valid && !result_stall;
    if (!rst) begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_EDGE_THRESHOLD: thr_now  = pwdata[7:0];
          REG_IMAGE_ROWS:     rows_now = pwdata[9:0];
          REG_IMAGE_COLS:     cols_now = pwdata[9:0];
          default: ;
        endcase
      end
      // check results before queueing a read accepted in the same cycle
      if (result_beat) begin
        if (bin_count_due.size() == 0) report_miss("result with no read pending", -1,
                                                   int'(bin_count));
        else if (bin_count_due[0] != bin_count)
          report_miss("bin count", int'(bin_count_due.pop_front()), int'(bin_count));
        else void'(bin_count_due.pop_front());
      end
      if (item_beat) begin
        it = '{func, pixel_row, pixel_col, magnitude, rho_index, theta_index};
        apply_item(it);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hough_line_vote_accumulator_unit: mismatch");
      $finish;
    end
  end

  // item driver
  bit feed_live = 1'b0;
  bit feed_burst = 1'b0;
  int feed_gap = 0;
  always @(negedge clk) begin
    hough_item_t it;
    if (!rst) begin
      if (feed_live && item_beat) feed_live = 1'b0;
      if (!feed_live) begin
        if (feed_gap > 0) feed_gap--;
        else if (pending.size() > 0) begin
          it = pending.pop_front();
          feed_live = 1'b1;
          if ($urandom_range(0, 19) == 0) feed_burst = !feed_burst;
          feed_gap = feed_burst ? 0 : $urandom_range(0, 14);
          func        <= it.op;
          pixel_row   <= it.row;
          pixel_col   <= it.col;
          magnitude   <= it.mag;
          rho_index   <= it.rho;
          theta_index <= it.theta;
        end
      end
      item_valid <= feed_live;
    end
  end

  // result sink: per-beat random stall plus the long hold-off
  bit rx_burst = 1'b0;
  int rx_wait = 0;
  always @(negedge clk) begin
    bit hold_now;
    if (result_beat) begin
      if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 14);
    end
    if (rx_wait > 0) begin
      rx_wait--;
      hold_now = 1'b1;
    end else begin
      hold_now = 1'b0;
    end
    result_stall <= hold_now || (hold_left > 0);
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] thr, input logic [9:0] rows,
                           input logic [9:0] cols);
    write_reg(REG_EDGE_THRESHOLD, 32'(thr));
    write_reg(REG_IMAGE_ROWS, 32'(rows));
    write_reg(REG_IMAGE_COLS, 32'(cols));
    @(posedge clk);
  endtask

  // wait for every read to come back, then for a vote still sweeping its angles
  task automatic settle();
    while (pending.size() != 0 || item_valid || bin_count_due.size() != 0)
      @(posedge clk);
    repeat (VOTE_DRAIN) @(posedge clk);
  endtask

  function automatic hough_item_t vote_item(input logic [8:0] row, input logic [8:0] col,
                                            input logic [7:0] mag);
    return '{FUNC_VOTE, row, col, mag, 11'($urandom), 8'($urandom)};
  endfunction

  function automatic hough_item_t bin_item(input logic [1:0] op, input int rho,
                                           input int theta);
    return '{op, 9'($urandom), 9'($urandom), 8'($urandom), 11'(rho), 8'(theta)};
  endfunction

  // a bin that a recently voted pixel hit, or a random one
  function automatic hough_item_t hit_item(input logic [1:0] op);
    logic [17:0] px;
    int t;
    int r;
    if (recent_px.size() == 0) return bin_item(op, $urandom_range(0, RHO_SPAN - 1),
                                               $urandom_range(0, ANGLES - 1));
    px = recent_px[$urandom_range(0, recent_px.size() - 1)];
    t  = $urandom_range(0, ANGLES - 1);
    r  = project_rho(px[17:9], px[8:0], t);
    if (r < 0 || r >= RHO_SPAN) r = $urandom_range(0, RHO_SPAN - 1);
    return bin_item(op, r, t);
  endfunction

  task automatic push_random(input int n);
    int sel;
    logic [8:0] row;
    logic [8:0] col;
    logic [7:0] mag;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        row = 9'($urandom);
        col = 9'($urandom);
        if (thr_now < 8'd255 && $urandom_range(0, 4) != 0)
          mag = 8'($urandom_range(int'(thr_now) + 1, 255));
        else
          mag = 8'($urandom);
        recent_px.insert(recent_px.size(), {row, col});
        if (recent_px.size() > 8) void'(recent_px.pop_front());
        enqueue_item(vote_item(row, col, mag));
      end else if (sel < 75) begin
        enqueue_item(hit_item(FUNC_READ));
      end else if (sel < 85) begin
        enqueue_item(bin_item(FUNC_READ, $urandom_range(0, 2047),
                              $urandom_range(0, 255)));
      end else if (sel < 89) begin
        enqueue_item(hit_item(FUNC_CLEAR));
      end else if (sel < 94) begin
        enqueue_item(bin_item(FUNC_CLEAR, $urandom_range(0, 2047),
                              $urandom_range(0, 255)));
      end else begin
        enqueue_item('{FUNC_SPARE, 9'($urandom), 9'($urandom), 8'($urandom),
                       11'($urandom), 8'($urandom)});
      end
    end
  endtask

  initial begin
    build_trig_tables();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // the unit sweeps its bin memory after reset with item_stall high
    @(posedge clk);
    while (item_stall) @(posedge clk);

    // reset settings: empty bins at the corners, then single pixels
    enqueue_item(bin_item(FUNC_READ, 0, 0));
    enqueue_item(bin_item(FUNC_READ, 2047, 179));
    enqueue_item(bin_item(FUNC_READ, 0, 180));
    enqueue_item(bin_item(FUNC_READ, 2047, 255));
    enqueue_item(vote_item(9'd0, 9'd0, 8'd255));
    enqueue_item(bin_item(FUNC_READ, 1024, 0));
    enqueue_item(bin_item(FUNC_READ, 1024, 179));
    enqueue_item(vote_item(9'd511, 9'd511, 8'd201));
    // magnitude equal to threshold casts no vote
    enqueue_item(vote_item(9'd511, 9'd511, 8'd200));
    enqueue_item(bin_item(FUNC_READ, project_rho(9'd511, 9'd511, 45), 45));
    enqueue_item(bin_item(FUNC_READ, project_rho(9'd511, 9'd511, 135), 135));
    enqueue_item(bin_item(FUNC_CLEAR, 1024, 0));
    enqueue_item(bin_item(FUNC_READ, 1024, 0));
    enqueue_item(bin_item(FUNC_CLEAR, 2047, 255));
    enqueue_item(bin_item(FUNC_CLEAR, 2047, 179));
    enqueue_item('{FUNC_SPARE, 9'h1FF, 9'h1FF, 8'hFF, 11'h7FF, 8'hFF});
    enqueue_item(vote_item(9'd0, 9'd511, 8'd255));
    enqueue_item(bin_item(FUNC_READ, project_rho(9'd0, 9'd511, 0), 0));
    enqueue_item(vote_item(9'd511, 9'd0, 8'd255));
    enqueue_item(bin_item(FUNC_READ, project_rho(9'd511, 9'd0, 90), 90));
    push_random(200);
    settle();

    // lowest threshold and offset: negative rho votes get dropped
    configure(8'd0, 10'd1, 10'd1);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    @(posedge clk);
    enqueue_item(vote_item(9'd0, 9'd0, 8'd0));
    enqueue_item(vote_item(9'd0, 9'd0, 8'd1));
    enqueue_item(bin_item(FUNC_READ, 2, 0));
    enqueue_item(bin_item(FUNC_READ, 2, 179));
    enqueue_item(vote_item(9'd0, 9'd511, 8'd255));
    enqueue_item(bin_item(FUNC_READ, 0, 179));
    push_random(200);
    settle();

    // highest threshold: nothing votes
    configure(8'd255, 10'd512, 10'd512);
    enqueue_item(vote_item(9'd100, 9'd100, 8'd255));
    enqueue_item(bin_item(FUNC_READ, project_rho(9'd100, 9'd100, 0), 0));
    push_random(60);
    settle();

    // sink holds off long enough for the unit to back up its item input
    configure(8'd128, 10'd300, 10'd17);
    @(negedge clk);
    hold_left <= LONG_HOLD;
    @(posedge clk);
    for (int i = 0; i < 40; i++) enqueue_item(hit_item(FUNC_READ));
    settle();
    push_random(200);
    settle();

    for (int p = 0; p < 3; p++) begin
      configure(8'($urandom), 10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)));
      push_random(140);
      settle();
    end

    if (mismatches == 0) begin
      $display("hough_line_vote_accumulator_unit: match");
    end else begin
      $display("hough_line_vote_accumulator_unit: mismatch");
    end
    $finish;
  end

endmodule
